[rtl/tdpf_pkg.sv]
// ----------------------------------------------------------------------------
// tdpf_pkg
// shared types, constants and the verdict function of the port filter
// ----------------------------------------------------------------------------
package tdpf_pkg;

	localparam int COUNTER_BITS = 64;
	localparam int CNT_OUT_W    = 64;

	localparam logic [7:0]  POS_ETYPE_HI  = 8'd12;
	localparam logic [7:0]  POS_ETYPE_LO  = 8'd13;
	localparam logic [7:0]  POS_VER_IHL   = 8'd14;
	localparam logic [7:0]  POS_TLEN_HI   = 8'd16;
	localparam logic [7:0]  POS_TLEN_LO   = 8'd17;
	localparam logic [7:0]  POS_PROTO     = 8'd23;
	localparam logic [7:0]  POS_MAX       = 8'd255;
	// ethernet header plus the two bytes of the tcp source port
	localparam logic [7:0]  PORT_BASE     = 8'd16;

	localparam logic [7:0]  ETH_HDR_LEN   = 8'd14;
	localparam logic [7:0]  ETH_IP_MIN    = 8'd34;
	localparam logic [15:0] TCP_MIN_HDR   = 16'd20;
	localparam logic [15:0] ETHERTYPE_IP4 = 16'h0800;
	localparam logic [3:0]  IP_VERSION4   = 4'd4;
	localparam logic [3:0]  IHL_MIN       = 4'd5;
	localparam logic [7:0]  PROTO_TCP     = 8'd6;
	localparam logic [15:0] BLOCKED_RESET = 16'd80;

	typedef enum logic [1:0] {
		VERDICT_FORWARD   = 2'd0,
		VERDICT_PORT      = 2'd1,
		VERDICT_MALFORMED = 2'd2
	} verdict_t;

	// captured view of a frame, including the byte being consumed
	typedef struct packed {
		logic [7:0]  len;
		logic [15:0] etype;
		logic [7:0]  ver_ihl;
		logic [15:0] ip_len;
		logic [7:0]  protocol;
		logic [15:0] dport;
	} frame_t;

	typedef struct packed {
		logic     load;
		verdict_t verdict;
	} result_t;

	function automatic verdict_t judge(frame_t f, logic [15:0] blocked);
		logic [7:0] hdr;
		verdict_t   v;
		hdr = {2'b00, f.ver_ihl[3:0], 2'b00};
		if (f.len < ETH_HDR_LEN) begin
			v = VERDICT_MALFORMED;
		end else if (f.etype != ETHERTYPE_IP4 || f.len < ETH_IP_MIN) begin
			v = VERDICT_FORWARD;
		end else if (f.ver_ihl[7:4] != IP_VERSION4) begin
			v = VERDICT_MALFORMED;
		end else if (f.ver_ihl[3:0] < IHL_MIN) begin
			v = VERDICT_MALFORMED;
		end else if (f.protocol != PROTO_TCP) begin
			v = VERDICT_FORWARD;
		end else if (hdr > f.len - ETH_HDR_LEN) begin
			v = VERDICT_FORWARD;
		end else if (f.ip_len < {8'd0, hdr} + TCP_MIN_HDR) begin
			v = VERDICT_FORWARD;
		end else if (f.len < hdr + ETH_IP_MIN) begin
			v = VERDICT_FORWARD;
		end else if (f.dport == blocked) begin
			v = VERDICT_PORT;
		end else begin
			v = VERDICT_FORWARD;
		end
		return v;
	endfunction

endpackage

[rtl/tdpf_if.sv]
// ----------------------------------------------------------------------------
// tdpf channel interfaces
// valid/ready channels for frame bytes and for per-packet results
// ----------------------------------------------------------------------------
interface tdpf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] packet_byte;
	logic       end_of_packet;

	modport source (output valid, packet_byte, end_of_packet, input ready);
	modport sink   (input valid, packet_byte, end_of_packet, output ready);
endinterface

interface tdpf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [63:0] total_count;
	logic [63:0] forwarded_count;
	logic [63:0] port_drop_count;
	logic [63:0] malformed_drop_count;

	modport source (output valid, verdict, total_count, forwarded_count, port_drop_count,
		malformed_drop_count, input ready);
	modport sink   (input valid, verdict, total_count, forwarded_count, port_drop_count,
		malformed_drop_count, output ready);
endinterface

[rtl/tcp_dest_port_packet_filter_top.sv]
// ----------------------------------------------------------------------------
// tcp_dest_port_packet_filter_top
// ipv4 tcp destination port filter over a byte stream of ethernet frames
// ----------------------------------------------------------------------------
// throughput: one byte per cycle; while a result waits unread, bytes keep
//   flowing until the next last byte, which holds in the input register
// results: the last byte of a frame passes the input register, then the
//   result register, which offers the verdict and counters; a full result
//   slot holds that last byte in the input register
// reset: arst_n clears byte position, captured fields, all counters and
//   the valid bits; blocked_port returns to 80
// ----------------------------------------------------------------------------
module tcp_dest_port_packet_filter_top import tdpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	tdpf_in_if.sink     pkt,
	tdpf_out_if.source  res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eop_s1;
	logic       fire_s1;

	logic [15:0] blocked_port_q;
	frame_t      frame_nxt;
	result_t     res_in;

	// a non-final byte never needs the result slot; a final byte needs it
	// empty or draining in this cycle
	assign fire_s1   = valid_s1 && (!eop_s1 || !res.valid || res.ready);
	assign pkt.ready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt.ready) begin
			valid_s1 <= pkt.valid;
		end
	end

	// payload of the input stage, no reset needed
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			byte_s1 <= pkt.packet_byte;
			eop_s1  <= pkt.end_of_packet;
		end
	end

	// blocked port register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_port_q <= BLOCKED_RESET;
		end else if (cfg_we) begin
			blocked_port_q <= cfg_wdata;
		end
	end

	// field capture; frame_nxt already includes the byte in stage 1
	tdpf_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_s1),
		.pkt_byte  (byte_s1),
		.eop       (eop_s1),
		.frame_nxt (frame_nxt)
	);

	// verdict on the last byte of the frame
	always_comb begin
		res_in.load    = fire_s1 && eop_s1;
		res_in.verdict = judge(frame_nxt, blocked_port_q);
	end

	// counters and result register
	tdpf_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.res_in (res_in),
		.res    (res)
	);

endmodule

[rtl/tdpf_capture.sv]
// ----------------------------------------------------------------------------
// tdpf_capture
// byte position and header field capture for the frame in flight
// ----------------------------------------------------------------------------
module tdpf_capture import tdpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  logic [7:0] pkt_byte,
	input  logic       eop,
	output frame_t     frame_nxt
);

	logic [7:0]  pos_q;
	logic [15:0] etype_q;
	logic [7:0]  ver_ihl_q;
	logic [15:0] tlen_q;
	logic [7:0]  proto_q;
	logic [15:0] dport_q;
	logic [7:0]  port_at;

	assign port_at = PORT_BASE + {2'b00, ver_ihl_q[3:0], 2'b00};

	always_comb begin
		frame_nxt.len      = (pos_q == POS_MAX) ? POS_MAX : pos_q + 8'd1;
		frame_nxt.etype    = etype_q;
		frame_nxt.ver_ihl  = ver_ihl_q;
		frame_nxt.ip_len   = tlen_q;
		frame_nxt.protocol = proto_q;
		frame_nxt.dport    = dport_q;
		if (pos_q == POS_ETYPE_HI) frame_nxt.etype[15:8]  = pkt_byte;
		if (pos_q == POS_ETYPE_LO) frame_nxt.etype[7:0]   = pkt_byte;
		if (pos_q == POS_VER_IHL)  frame_nxt.ver_ihl      = pkt_byte;
		if (pos_q == POS_TLEN_HI)  frame_nxt.ip_len[15:8] = pkt_byte;
		if (pos_q == POS_TLEN_LO)  frame_nxt.ip_len[7:0]  = pkt_byte;
		if (pos_q == POS_PROTO)    frame_nxt.protocol     = pkt_byte;
		// port offset uses the ihl captured earlier in this frame
		if (pos_q > POS_VER_IHL) begin
			if (pos_q == port_at)         frame_nxt.dport[15:8] = pkt_byte;
			if (pos_q == port_at + 8'd1)  frame_nxt.dport[7:0]  = pkt_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			etype_q   <= '0;
			ver_ihl_q <= '0;
			tlen_q    <= '0;
			proto_q   <= '0;
			dport_q   <= '0;
		end else if (fire) begin
			if (eop) begin
				pos_q     <= '0;
				etype_q   <= '0;
				ver_ihl_q <= '0;
				tlen_q    <= '0;
				proto_q   <= '0;
				dport_q   <= '0;
			end else begin
				pos_q     <= frame_nxt.len;
				etype_q   <= frame_nxt.etype;
				ver_ihl_q <= frame_nxt.ver_ihl;
				tlen_q    <= frame_nxt.ip_len;
				proto_q   <= frame_nxt.protocol;
				dport_q   <= frame_nxt.dport;
			end
		end
	end

endmodule

[rtl/tdpf_counters.sv]
// ----------------------------------------------------------------------------
// tdpf_counters
// packet counters and the result register that drives the output channel
// ----------------------------------------------------------------------------
module tdpf_counters import tdpf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  result_t     res_in,
	tdpf_out_if.source  res
);

	logic [COUNTER_BITS-1:0] total_q;
	logic [COUNTER_BITS-1:0] fwd_q;
	logic [COUNTER_BITS-1:0] port_q;
	logic [COUNTER_BITS-1:0] mal_q;
	logic [COUNTER_BITS-1:0] total_nxt;
	logic [COUNTER_BITS-1:0] fwd_nxt;
	logic [COUNTER_BITS-1:0] port_nxt;
	logic [COUNTER_BITS-1:0] mal_nxt;
	logic                    valid_q;
	verdict_t                verdict_q;

	always_comb begin
		total_nxt = total_q + COUNTER_BITS'(1);
		fwd_nxt   = fwd_q;
		port_nxt  = port_q;
		mal_nxt   = mal_q;
		case (res_in.verdict)
			VERDICT_FORWARD: fwd_nxt  = fwd_q + COUNTER_BITS'(1);
			VERDICT_PORT:    port_nxt = port_q + COUNTER_BITS'(1);
			default:         mal_nxt  = mal_q + COUNTER_BITS'(1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			fwd_q   <= '0;
			port_q  <= '0;
			mal_q   <= '0;
			valid_q <= 1'b0;
		end else if (res_in.load) begin
			total_q <= total_nxt;
			fwd_q   <= fwd_nxt;
			port_q  <= port_nxt;
			mal_q   <= mal_nxt;
			valid_q <= 1'b1;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_in.load) verdict_q <= res_in.verdict;
	end

	assign res.valid                = valid_q;
	assign res.verdict              = verdict_q;
	assign res.total_count          = CNT_OUT_W'(total_q);
	assign res.forwarded_count      = CNT_OUT_W'(fwd_q);
	assign res.port_drop_count      = CNT_OUT_W'(port_q);
	assign res.malformed_drop_count = CNT_OUT_W'(mal_q);

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for tcp_dest_port_packet_filter_top
// Streams ethernet frames byte by byte into the filter and predicts the
// verdict and the four packet counters of every frame. Each result transfer
// is compared field by field. The run covers runt and oversized frames,
// broken ipv4 headers and several blocked port settings. Both channels
// idle at random, and the result side holds off long enough to stall input.
// ----------------------------------------------------------------------------
module testbench import tdpf_pkg::*;;

	// result side hold-off, long enough to back up the result path
	localparam int HOLD_CYCLES    = 400;
	// cycles without any transfer before the run is declared hung
	localparam int WATCHDOG_LIMIT = 3000;
	// byte target of each random phase, six phases in all
	localparam int PHASE_BYTES    = 40;
	localparam int PHASES         = 6;

	// one expected result transfer
	typedef struct packed {
		verdict_t    verdict;
		logic [63:0] total;
		logic [63:0] forwarded;
		logic [63:0] port_drops;
		logic [63:0] malformed_drops;
	} filter_outcome_t;

	// tracks frame parsing and counters, queues the outcome of each frame
	class port_filter_tracker;
		logic [15:0]     blocked_port;
		logic [7:0]      byte_pos;
		logic [15:0]     eth_word;
		logic [7:0]      ver_ihl;
		logic [15:0]     ip_length;
		logic [7:0]      protocol;
		logic [15:0]     dest_port;
		logic [63:0]     n_total;
		logic [63:0]     n_forwarded;
		logic [63:0]     n_port_drops;
		logic [63:0]     n_malformed;
		filter_outcome_t awaited[$];
		int              errors;
		int              by_verdict[3];

		function new();
			blocked_port = BLOCKED_RESET;
			n_total      = '0;
			n_forwarded  = '0;
			n_port_drops = '0;
			n_malformed  = '0;
			errors       = 0;
			by_verdict   = '{0, 0, 0};
			clear_frame();
		endfunction

		function void clear_frame();
			byte_pos  = '0;
			eth_word  = '0;
			ver_ihl   = '0;
			ip_length = '0;
			protocol  = '0;
			dest_port = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function verdict_t classify(int len);
			int hdr;
			hdr = 4 * int'(ver_ihl[3:0]);
			if (len < int'(ETH_HDR_LEN))
				return VERDICT_MALFORMED;
			if (eth_word != ETHERTYPE_IP4 || len < int'(ETH_IP_MIN))
				return VERDICT_FORWARD;
			if (ver_ihl[7:4] != IP_VERSION4)
				return VERDICT_MALFORMED;
			if (ver_ihl[3:0] < IHL_MIN)
				return VERDICT_MALFORMED;
			if (protocol != PROTO_TCP)
				return VERDICT_FORWARD;
			if (hdr > len - int'(ETH_HDR_LEN))
				return VERDICT_FORWARD;
			if (int'(ip_length) < hdr + int'(TCP_MIN_HDR))
				return VERDICT_FORWARD;
			if (len < int'(ETH_IP_MIN) + hdr)
				return VERDICT_FORWARD;
			if (dest_port == blocked_port)
				return VERDICT_PORT;
			return VERDICT_FORWARD;
		endfunction

		function void note_byte(logic [7:0] data, logic last);
			int              pos;
			int              len;
			int              port_at;
			filter_outcome_t rec;
			pos = int'(byte_pos);
			if (pos == int'(POS_ETYPE_HI)) eth_word[15:8] = data;
			if (pos == int'(POS_ETYPE_LO)) eth_word[7:0] = data;
			if (pos == int'(POS_VER_IHL)) ver_ihl = data;
			if (pos == int'(POS_TLEN_HI)) ip_length[15:8] = data;
			if (pos == int'(POS_TLEN_LO)) ip_length[7:0] = data;
			if (pos == int'(POS_PROTO)) protocol = data;
			if (pos > int'(POS_VER_IHL)) begin
				port_at = int'(PORT_BASE) + 4 * int'(ver_ihl[3:0]);
				if (pos == port_at) dest_port[15:8] = data;
				if (pos == port_at + 1) dest_port[7:0] = data;
			end
			len = (pos < int'(POS_MAX)) ? pos + 1 : int'(POS_MAX);
			byte_pos = len[7:0];
			if (!last)
				return;
			rec.verdict = classify(len);
			n_total += 64'd1;
			case (rec.verdict)
				VERDICT_FORWARD: n_forwarded += 64'd1;
				VERDICT_PORT:    n_port_drops += 64'd1;
				default:         n_malformed += 64'd1;
			endcase
			rec.total           = n_total;
			rec.forwarded       = n_forwarded;
			rec.port_drops      = n_port_drops;
			rec.malformed_drops = n_malformed;
			awaited.push_back(rec);
			by_verdict[rec.verdict]++;
			clear_frame();
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(logic [1:0] verdict, logic [63:0] total,
				logic [63:0] forwarded, logic [63:0] port_drops,
				logic [63:0] malformed_drops);
			filter_outcome_t want;
			if (awaited.size() == 0) begin
				$error("result transfer with no frame outstanding");
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare_field("verdict", 64'(want.verdict), 64'(verdict));
			compare_field("total_count", want.total, total);
			compare_field("forwarded_count", want.forwarded, forwarded);
			compare_field("port_drop_count", want.port_drops, port_drops);
			compare_field("malformed_drop_count", want.malformed_drops, malformed_drops);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	tdpf_in_if  byte_ch();
	tdpf_out_if result_ch();

	tcp_dest_port_packet_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (byte_ch),
		.res       (result_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	port_filter_tracker outcome_tracker;

	logic [7:0] frame_buf[$];
	bit         hold_request = 1'b0;
	int         frames_sent = 0;
	int         bytes_sent = 0;
	int         stall_cycles = 0;
	int         port_settings = 0;
	int         quiet_cycles = 0;

	always #4 clk = ~clk;

	// idle length for either side: mostly none or short, now and then long
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 4);
		return $urandom_range(12, 48);
	endfunction

	// ------------------------------------------------------------------------
	// frame construction
	// ------------------------------------------------------------------------

	// fill < 0 gives random content, otherwise every byte is fill
	function automatic void fill_frame(int len, int fill);
		frame_buf.delete();
		repeat (len)
			frame_buf.push_back(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
	endfunction

	// header fields beyond the end of a short frame are simply dropped
	function automatic void put_byte(int pos, logic [7:0] data);
		if (pos < frame_buf.size())
			frame_buf[pos] = data;
	endfunction

	function automatic void stamp_headers(logic [15:0] etype, logic [7:0] vi,
			logic [15:0] tlen, logic [7:0] proto, logic [15:0] dport);
		int port_at;
		port_at = int'(PORT_BASE) + 4 * int'(vi[3:0]);
		put_byte(int'(POS_ETYPE_HI), etype[15:8]);
		put_byte(int'(POS_ETYPE_LO), etype[7:0]);
		put_byte(int'(POS_VER_IHL), vi);
		put_byte(int'(POS_TLEN_HI), tlen[15:8]);
		put_byte(int'(POS_TLEN_LO), tlen[7:0]);
		put_byte(int'(POS_PROTO), proto);
		// a short ihl puts the port on top of the ip fields, as the block sees it
		put_byte(port_at, dport[15:8]);
		put_byte(port_at + 1, dport[7:0]);
	endfunction

	// ------------------------------------------------------------------------
	// byte channel driver
	// ------------------------------------------------------------------------

	// offer one byte and hold it until the transfer
	task automatic push_byte(input logic [7:0] data, input logic last);
		byte_ch.valid         <= 1'b1;
		byte_ch.packet_byte   <= data;
		byte_ch.end_of_packet <= last;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
	endtask

	// valid stays high after the last byte so a following frame runs on
	// without a bubble; drain_results lowers it
	task automatic send_frame(input bit gaps);
		int idle;
		foreach (frame_buf[i]) begin
			idle = gaps ? idle_cycles() : 0;
			if (idle > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			push_byte(frame_buf[i], i == frame_buf.size() - 1);
		end
		frames_sent++;
		bytes_sent += frame_buf.size();
	endtask

	task automatic directed_frame(input int len, input logic [15:0] etype,
			input logic [7:0] vi, input logic [15:0] tlen, input logic [7:0] proto,
			input logic [15:0] dport);
		fill_frame(len, -1);
		stamp_headers(etype, vi, tlen, proto, dport);
		send_frame(1'b1);
	endtask

	// mostly well-formed tcp frames with random content, the rest broken
	// in one field or plain noise
	task automatic random_frame(input bit gaps);
		int          r;
		int          ihl;
		int          hdr;
		int          body;
		int          len;
		logic [15:0] etype;
		logic [15:0] tlen;
		logic [15:0] dport;
		logic [7:0]  vi;
		logic [7:0]  proto;
		ihl   = $urandom_range(0, 1) ? 5 : $urandom_range(5, 15);
		hdr   = 4 * ihl;
		body  = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 240) : $urandom_range(0, 24);
		len   = int'(ETH_IP_MIN) + hdr + body;
		etype = ETHERTYPE_IP4;
		vi    = {IP_VERSION4, 4'(ihl)};
		tlen  = 16'(hdr + int'(TCP_MIN_HDR) + body + $urandom_range(0, 3));
		proto = PROTO_TCP;
		r = $urandom_range(0, 99);
		if (r < 40)
			dport = outcome_tracker.blocked_port;
		else if (r < 50)
			dport = outcome_tracker.blocked_port + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
		else
			dport = 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 99) >= 65) begin
			case ($urandom_range(0, 7))
				0: len = $urandom_range(1, int'(ETH_IP_MIN) + hdr - 1);
				1: tlen = 16'($urandom_range(0, hdr + int'(TCP_MIN_HDR) - 1));
				2: proto = 8'($urandom_range(0, 255));
				3: etype = 16'($urandom_range(0, 65535));
				4: vi[7:4] = 4'($urandom_range(0, 15));
				5: vi[3:0] = 4'($urandom_range(0, 4));
				6: tlen = 16'($urandom_range(0, 65535));
				default: begin
					// raw noise, no header stamped
					fill_frame($urandom_range(1, 90), -1);
					send_frame(gaps);
					return;
				end
			endcase
		end
		fill_frame(len, -1);
		stamp_headers(etype, vi, tlen, proto, dport);
		send_frame(gaps);
	endtask

	// stop offering, wait for every outstanding result, then let the
	// two-stage pipe settle
	task automatic drain_results();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (outcome_tracker.pending() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// register write only with the block idle
	task automatic write_blocked_port(input logic [15:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		outcome_tracker.blocked_port = value;
		port_settings++;
	endtask

	// ------------------------------------------------------------------------
	// result side: random ready with long free-running stretches, plus one
	// long hold-off on request
	// ------------------------------------------------------------------------
	initial begin
		int run;
		int idle;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
			result_ch.ready <= 1'b1;
			for (int k = 0; k < run && !hold_request; k++)
				@(posedge clk);
			idle = idle_cycles();
			if (idle > 0 && !hold_request) begin
				result_ch.ready <= 1'b0;
				for (int k = 0; k < idle && !hold_request; k++)
					@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor and watchdog: both channels sampled at the rising edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (byte_ch.valid && byte_ch.ready)
				outcome_tracker.note_byte(byte_ch.packet_byte, byte_ch.end_of_packet);
			if (result_ch.valid && result_ch.ready)
				outcome_tracker.check_outcome(result_ch.verdict, result_ch.total_count,
					result_ch.forwarded_count, result_ch.port_drop_count,
					result_ch.malformed_drop_count);
			if (byte_ch.valid && !byte_ch.ready)
				stall_cycles++;
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int          phase_start;
		logic [15:0] setting;
		outcome_tracker = new();
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		byte_ch.valid         <= 1'b0;
		byte_ch.packet_byte   <= '0;
		byte_ch.end_of_packet <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, blocked port at its reset value
		// runts shorter than an ethernet header
		directed_frame(1, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		directed_frame(13, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		// ethernet header alone, then ipv4 one byte short of a full ip header
		directed_frame(14, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		directed_frame(33, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		// not ipv4
		directed_frame(40, 16'h86DD, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		// bad version, header length below five words
		directed_frame(40, ETHERTYPE_IP4, 8'h65, 16'd40, PROTO_TCP, 16'd80);
		directed_frame(40, ETHERTYPE_IP4, 8'h44, 16'd40, PROTO_TCP, 16'd80);
		directed_frame(40, ETHERTYPE_IP4, 8'h40, 16'd40, PROTO_TCP, 16'd80);
		// udp to the blocked port passes
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd40, 8'd17, 16'd80);
		// minimal tcp to the blocked port and to its neighbor
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd81);
		// total length one short, then frame one byte short
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd39, PROTO_TCP, 16'd80);
		directed_frame(53, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		// largest ip header, then an ip header longer than the frame
		directed_frame(94, ETHERTYPE_IP4, 8'h4F, 16'd80, PROTO_TCP, 16'd80);
		directed_frame(60, ETHERTYPE_IP4, 8'h4F, 16'd80, PROTO_TCP, 16'd80);
		// byte count saturation past 255
		directed_frame(256, ETHERTYPE_IP4, 8'h45, 16'd242, PROTO_TCP, 16'd80);
		// all-zero and all-one frames
		fill_frame(40, 0);
		send_frame(1'b1);
		fill_frame(40, 255);
		send_frame(1'b1);
		// port zero compares like any other value
		write_blocked_port(16'd0);
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd0);
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'd80);
		write_blocked_port(16'hFFFF);
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'hFFFF);
		directed_frame(54, ETHERTYPE_IP4, 8'h45, 16'd40, PROTO_TCP, 16'hFFFE);

		// random phases, each with its own blocked port setting
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       setting = 16'd1;
				1:       setting = 16'hFFFF;
				2:       setting = BLOCKED_RESET;
				default: setting = 16'($urandom_range(1, 65535));
			endcase
			write_blocked_port(setting);
			if (phase == 3) begin
				// short frames back to back while results are held off,
				// so the result path fills and the byte channel stalls
				hold_request = 1'b1;
				repeat (12) begin
					fill_frame($urandom_range(1, 24), -1);
					send_frame(1'b0);
				end
			end
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) begin
				// phase five runs without sender gaps
				random_frame(phase != 5);
			end
		end

		drain_results();
		$display("summary: %0d frames, %0d bytes, %0d blocked port settings",
			frames_sent, bytes_sent, port_settings + 1);
		$display("summary: forwarded %0d, port drops %0d, malformed %0d, %0d input stall cycles",
			outcome_tracker.by_verdict[VERDICT_FORWARD], outcome_tracker.by_verdict[VERDICT_PORT],
			outcome_tracker.by_verdict[VERDICT_MALFORMED], stall_cycles);
		if (outcome_tracker.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
